### rtl/core/mlq_pkg.sv
`timescale 1ns / 1ps

package mlq_pkg;

   localparam int MAX_LEVELS  = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int ITEM_WIDTH  = 32;

   localparam int LVL_W  = 3;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = LVL_W + PTR_W;
   localparam int USED_W = 4;

   localparam logic [USED_W-1:0] MAX_LEVELS_V  = USED_W'(MAX_LEVELS);
   localparam logic [CNT_W-1:0]  QUEUE_DEPTH_V = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST      = PTR_W'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_LEVEL = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // Outcome of one transaction, decided at the accepting edge.
   typedef struct packed {
      status_type       status;
      logic [LVL_W-1:0] found_level;
      logic             pop;
   } decision_type;

endpackage

### rtl/core/multilevel_queue_rotating_dequeue.sv
`timescale 1ns / 1ps
// Channel | Dir | Contents
// req_    | in  | tuser: req_type; tdata: level[2:0], item_in[34:3], zero pad
// rsp_    | out | tuser: status; tdata: found_level[2:0], item_out[34:3], zero pad
// csr_    | cfg | register 0 at byte 0: num_levels[3:0]
//
// For each transaction the accepting edge decides the outcome, moves the level
// pointers, issues the item memory write or read and enters S_DONE; from S_DONE
// the result register is loaded from the read port of the single-port memory.
// A stalled result holds the block in S_DONE; the input is taken again once
// the result register has room. Reset clears the pointers and fill counts at
// once and sets num_levels to 8; no clearing pass.

module multilevel_queue_rotating_dequeue
   import mlq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // level[2:0], item_in[34:3], zero[39:35]
   input  logic        req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // found_level[2:0], item_out[34:3], zero[39:35]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic {
      S_IDLE,
      S_DONE
   } state_type;

   localparam logic REG_NUM_LEVELS = 1'b0;

   state_type             state_ff, state_in;
   decision_type          pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [LVL_W-1:0]      rsp_level_ff, rsp_level_in;
   logic [ITEM_WIDTH-1:0] rsp_item_ff, rsp_item_in;
   logic [USED_W-1:0]     num_levels_ff, num_levels_in;

   logic                  acc;
   logic                  csr_wr;
   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_addr;
   logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;
   decision_type          dec;

   assign req_tready = (state_ff == S_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   mlq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .req_type   (req_tuser),
      .level      (req_tdata[LVL_W-1:0]),
      .item_in    (req_tdata[LVL_W+ITEM_WIDTH-1:LVL_W]),
      .num_levels (num_levels_ff),
      .ram_we     (ram_we),
      .ram_re     (ram_re),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .dec        (dec)
   );

   mlq_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (MAX_LEVELS * (2 ** PTR_W))
   ) u_item_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_item_in   = rsp_item_ff;
      num_levels_in = num_levels_ff;

      // drop the result once the consumer has taken it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               pend_in  = dec;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free, then load it
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_ff.status;
               rsp_level_in  = pend_ff.found_level;
               rsp_item_in   = pend_ff.pop ? ram_rdata : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr && (csr_paddr[2] == REG_NUM_LEVELS)) begin
         num_levels_in = csr_pwdata[USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_level_ff  <= '0;
         rsp_item_ff   <= '0;
         num_levels_ff <= MAX_LEVELS_V;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_item_ff   <= rsp_item_in;
         num_levels_ff <= num_levels_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_item_ff, rsp_level_ff};
   assign csr_prdata = (csr_paddr[2] == REG_NUM_LEVELS) ?
                       {28'b0, num_levels_ff} : 32'b0;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      acc |=> !req_tready)
      else $error("input taken again in the cycle after a transaction");

   a_failed_result_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == 40'b0))
      else $error("failed result carries a level or an item");

   a_pop_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && pend_ff.pop |-> (pend_ff.status == ST_OK))
      else $error("memory read issued for a failed dequeue");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside the completion cycle");
`endif

endmodule

### rtl/core/mlq_ram.sv
`timescale 1ns / 1ps

module mlq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/mlq_ctrl.sv
`timescale 1ns / 1ps

module mlq_ctrl
   import mlq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  acc,
   input  logic                  req_type,
   input  logic [LVL_W-1:0]      level,
   input  logic [ITEM_WIDTH-1:0] item_in,
   input  logic [USED_W-1:0]     num_levels,
   output logic                  ram_we,
   output logic                  ram_re,
   output logic [ADDR_W-1:0]     ram_addr,
   output logic [ITEM_WIDTH-1:0] ram_wdata,
   output decision_type          dec
);

   logic [PTR_W-1:0] head_ff [MAX_LEVELS];
   logic [PTR_W-1:0] head_in [MAX_LEVELS];
   logic [PTR_W-1:0] tail_ff [MAX_LEVELS];
   logic [PTR_W-1:0] tail_in [MAX_LEVELS];
   logic [CNT_W-1:0] cnt_ff  [MAX_LEVELS];
   logic [CNT_W-1:0] cnt_in  [MAX_LEVELS];

   logic [USED_W-1:0]     used;
   logic                  bad;
   logic                  full;
   logic [MAX_LEVELS-1:0] nonempty;
   logic                  hi_hit, lo_hit;
   logic [LVL_W-1:0]      hi_idx, lo_idx, found;
   logic [PTR_W-1:0]      tail_cur, head_cur;
   logic                  do_push, do_pop;

   assign used = (num_levels > MAX_LEVELS_V) ? MAX_LEVELS_V : num_levels;
   assign bad  = {1'b0, level} >= used;
   assign full = cnt_ff[level] == QUEUE_DEPTH_V;

   // Rotating search: first non-empty level at or above the start, else the lowest.
   always_comb begin
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_idx = '0;
      lo_idx = '0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         nonempty[i] = (cnt_ff[i] != '0) && (USED_W'(i) < used);
         if (nonempty[i]) begin
            lo_hit = 1'b1;
            lo_idx = LVL_W'(i);
            if (LVL_W'(i) >= level) begin
               hi_hit = 1'b1;
               hi_idx = LVL_W'(i);
            end
         end
      end
   end

   assign found    = hi_hit ? hi_idx : lo_idx;
   assign tail_cur = tail_ff[level];
   assign head_cur = head_ff[found];
   assign do_push  = acc && !bad && (req_type == REQ_ENQUEUE) && !full;
   assign do_pop   = acc && !bad && (req_type == REQ_DEQUEUE) && lo_hit;

   always_comb begin
      if (bad) begin
         dec.status = ST_BAD_LEVEL;
      end else if (req_type == REQ_ENQUEUE) begin
         dec.status = full ? ST_FULL : ST_OK;
      end else begin
         dec.status = lo_hit ? ST_OK : ST_EMPTY;
      end
      dec.found_level = (!bad && (req_type == REQ_DEQUEUE) && lo_hit) ? found : '0;
      dec.pop         = !bad && (req_type == REQ_DEQUEUE) && lo_hit;
   end

   assign ram_we    = do_push;
   assign ram_re    = do_pop;
   assign ram_addr  = do_push ? {level, tail_cur} : {found, head_cur};
   assign ram_wdata = item_in;

   always_comb begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         cnt_in[i]  = cnt_ff[i];
      end
      if (do_push) begin
         tail_in[level] = (tail_cur == PTR_LAST) ? '0 : tail_cur + 1'b1;
         cnt_in[level]  = cnt_ff[level] + 1'b1;
      end
      if (do_pop) begin
         head_in[found] = (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
         cnt_in[found]  = cnt_ff[found] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (reset) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end else begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mlq_pkg::*;

   // Expected result of one request transaction
   typedef struct {
      status_type            status;
      logic [LVL_W-1:0]      found_level;
      logic [ITEM_WIDTH-1:0] item;
   } sched_result_type;

   localparam logic [2:0] ADDR_NUM_LEVELS = 3'd0;
   localparam int         LONG_HOLD       = 300;   // receiver hold-off, in cycles
   localparam int         RANDOM_ITEMS    = 900;
   localparam int         PHASES          = 8;
   localparam int         MAX_REPORTS     = 10;

   // Shadow of the per-level FIFOs and of num_levels; predicts one result per request
   // and holds the results still owed by the block.
   class queue_predictor;
      logic [ITEM_WIDTH-1:0] item_store [MAX_LEVELS][QUEUE_DEPTH];
      logic [PTR_W-1:0]      head_ptr [MAX_LEVELS];
      logic [PTR_W-1:0]      tail_ptr [MAX_LEVELS];
      int                    fill [MAX_LEVELS];
      logic [USED_W-1:0]     num_levels;
      sched_result_type      pending_results [$];
      int                    mismatches;
      int                    requests;
      int                    tally [4];

      function void reset_state();
         for (int l = 0; l < MAX_LEVELS; l++) begin
            head_ptr[l] = '0;
            tail_ptr[l] = '0;
            fill[l]     = 0;
         end
         num_levels  = MAX_LEVELS_V;
         mismatches  = 0;
         requests    = 0;
         tally       = '{0, 0, 0, 0};
      endfunction

      function void note_request(logic rtype, logic [LVL_W-1:0] lvl,
                                 logic [ITEM_WIDTH-1:0] word);
         sched_result_type want;
         int               used;
         int               idx;
         used             = (num_levels > MAX_LEVELS) ? MAX_LEVELS : int'(num_levels);
         want.status      = ST_OK;
         want.found_level = '0;
         want.item        = '0;
         if (lvl >= used) begin
            want.status = ST_BAD_LEVEL;
         end else if (rtype == REQ_ENQUEUE) begin
            if (fill[lvl] >= QUEUE_DEPTH) begin
               want.status = ST_FULL;   // drop the item
            end else begin
               item_store[lvl][tail_ptr[lvl]] = word;
               tail_ptr[lvl] = PTR_W'((tail_ptr[lvl] + 1) % QUEUE_DEPTH);
               fill[lvl]++;
            end
         end else begin
            // search upward from the start level, wrapping within the levels in use
            want.status = ST_EMPTY;
            idx = lvl;
            for (int n = 0; n < used; n++) begin
               if (fill[idx] != 0) begin
                  want.status      = ST_OK;
                  want.found_level = LVL_W'(idx);
                  want.item        = item_store[idx][head_ptr[idx]];
                  head_ptr[idx]    = PTR_W'((head_ptr[idx] + 1) % QUEUE_DEPTH);
                  fill[idx]--;
                  break;
               end
               idx = (idx + 1) % used;
            end
         end
         pending_results.push_back(want);
         requests++;
         tally[want.status]++;
      endfunction

      function void check_response(logic [1:0] st, logic [LVL_W-1:0] lvl,
                                   logic [ITEM_WIDTH-1:0] word);
         sched_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing outstanding: %s %0d level %0d item %h",
                        $realtime, "status", st, lvl, word);
            return;
         end
         want = pending_results.pop_front();
         if (st !== want.status || lvl !== want.found_level || word !== want.item) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: mismatch: expected status %0d level %0d item %h, %s",
                        $realtime, want.status, want.found_level, want.item,
                        $sformatf("got status %0d level %0d item %h", st, lvl, word));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // level[2:0], item_in[34:3], zero[39:35]
   logic        req_tuser;    // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // found_level[2:0], item_out[34:3], zero[39:35]
   logic [1:0]  rsp_tuser;    // status[1:0]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   queue_predictor pred;
   bit             steady;          // no new idle gaps on either side while set
   bit             long_hold_due;   // ask the receiver for one long hold-off
   int             stall_left;

   multilevel_queue_rotating_dequeue dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request transaction, hold it until accepted, then idle for a random gap
   task automatic send_request(input logic rtype, input logic [LVL_W-1:0] lvl,
                               input logic [ITEM_WIDTH-1:0] word);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= rtype;
      req_tdata  <= {5'd0, word, lvl};
      do @(posedge clock); while (!req_tready);
      pred.note_request(rtype, lvl, word);
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write num_levels once the block has delivered every owed result
   task automatic write_num_levels(input logic [USED_W-1:0] value);
      logic [31:0] filler;
      filler = $urandom;
      while (pred.pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);   // let the result register settle empty
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_NUM_LEVELS;
      csr_pwdata  <= {filler[31:USED_W], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      pred.num_levels = value;
   endtask

   // Result side: check each accepted transaction, then decide tready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            pred.check_response(rsp_tuser, rsp_tdata[2:0], rsp_tdata[34:3]);
         if (long_hold_due) begin
            // hold off long enough for the block to fill and stall its input
            long_hold_due = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [USED_W-1:0]     level_plan [PHASES];
      logic                  rtype;
      logic [LVL_W-1:0]      lvl;
      logic [ITEM_WIDTH-1:0] word;
      int                    used;
      int                    enq_pct;
      int                    per_phase;

      pred = new;
      pred.reset_state();
      level_plan    = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2, 4'd7};
      per_phase     = RANDOM_ITEMS / PHASES;
      steady        = 1'b0;
      long_hold_due = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= REQ_ENQUEUE;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_NUM_LEVELS;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset setting of eight levels.
      // Dequeue from an empty block, from the bottom and the top start level.
      send_request(REQ_DEQUEUE, 3'd0, '0);
      send_request(REQ_DEQUEUE, 3'd7, '1);
      // Extreme item words at the extreme levels
      send_request(REQ_ENQUEUE, 3'd7, '1);
      send_request(REQ_ENQUEUE, 3'd0, '0);
      send_request(REQ_DEQUEUE, 3'd7, '0);
      // Search from the middle must wrap round to level 0
      send_request(REQ_DEQUEUE, 3'd3, '0);
      // Fill one level to the brim, then one more is refused and dropped
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_request(REQ_ENQUEUE, 3'd2, 32'h5A5A_0000 | i);
      send_request(REQ_ENQUEUE, 3'd2, 32'hDEAD_BEEF);
      send_request(REQ_DEQUEUE, 3'd4, '0);
      req_tvalid <= 1'b0;

      // Random phases, each under its own level count: zero, one, the full eight and
      // a value above the maximum among them. Lowering the count strands upper levels
      // until a later phase brings them back.
      for (int p = 0; p < PHASES; p++) begin
         write_num_levels(level_plan[p]);
         used = (level_plan[p] > MAX_LEVELS) ? MAX_LEVELS : int'(level_plan[p]);
         if (p == 0)
            long_hold_due = 1'b1;
         for (int k = 0; k < per_phase; k++) begin
            if (k % 28 == 0)
               steady = ($urandom_range(0, 4) == 0);
            // enqueue-heavy first half fills levels, dequeue-heavy second half drains them
            enq_pct = (k < per_phase / 2) ? 70 : 30;
            rtype   = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
            if (used > 0 && $urandom_range(0, 3) != 0)
               lvl = LVL_W'($urandom_range(0, used - 1));
            else
               lvl = LVL_W'($urandom_range(0, MAX_LEVELS - 1));
            case ($urandom_range(0, 9))
               0:       word = '0;
               1:       word = '1;
               default: word = $urandom;
            endcase
            send_request(rtype, lvl, word);
         end
         req_tvalid <= 1'b0;
      end

      // Drain: wait for every owed result, then watch for stray ones
      steady = 1'b0;
      while (pred.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d request transactions: %0d ok, %0d bad level, %s",
               pred.requests, pred.tally[ST_OK], pred.tally[ST_BAD_LEVEL],
               $sformatf("%0d empty, %0d full.", pred.tally[ST_EMPTY],
                         pred.tally[ST_FULL]));
      $display("Level counts used: 8, 3, 0, 15, 1, 5, 8, 2, 7; %0d mismatches.",
               pred.mismatches);
      if (pred.mismatches == 0 && pred.pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("Timed out with %0d results outstanding.", pred.pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
